### design/rgba8_source_over_blend_surface_top_macros.svh
// Assertion macros for the RGBA8 source-over blend surface.
// Used by the top level only; no other dependencies.
`ifndef RGBA8_SOURCE_OVER_BLEND_SURFACE_TOP_MACROS_SVH
`define RGBA8_SOURCE_OVER_BLEND_SURFACE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RSOB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define RSOB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);
`else
`define RSOB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define RSOB_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### design/rsob_pkg.sv
// Shared types, constants and helpers for the RGBA8 source-over blend surface.
// No dependencies.
package rsob_pkg;

  localparam int unsigned CHAN_W         = 8;
  localparam int unsigned POS_W          = 16;
  localparam int unsigned DIM_W          = 9;
  localparam int unsigned DIM_RESET      = 256;
  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned APB_AW         = 3;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned PIX_W          = 4 * CHAN_W;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic {
    REQ_BLEND = 1'b0,
    REQ_READ  = 1'b1
  } rsob_req_e;

  typedef enum logic {
    REG_SURF_WIDTH  = 1'b0,
    REG_SURF_HEIGHT = 1'b1
  } rsob_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MIX,
    ST_NUM,
    ST_DIV,
    ST_WRITE
  } rsob_state_e;

  // Classified request as it travels from front to back.
  typedef struct packed {
    logic              is_read;
    logic              in_surf;
    logic [CHAN_W-1:0] src_red;
    logic [CHAN_W-1:0] src_green;
    logic [CHAN_W-1:0] src_blue;
    logic [15:0]       sa_prod;
  } rsob_item_t;

  typedef struct packed {
    logic              sel;
    logic              enable;
    logic              write;
    logic [APB_AW-1:0] addr;
    logic [APB_DW-1:0] wdata;
  } rsob_apb_req_t;

  // Floor division by 255 for values below 2^24: reciprocal estimate
  // (x * 65793) >> 24 is low by at most one, fixed with one compare.
  function automatic logic [15:0] div255(input logic [23:0] x);
    logic [40:0] est;
    logic [16:0] q0;
    logic [24:0] r;
    est = {x, 16'h0000} + {8'h00, x, 8'h00} + {16'h0000, x} + 41'd0;
    q0  = est[40:24];
    r   = {1'b0, x} - ({q0, 8'h00} - {8'h00, q0});
    if (r >= 25'd255) begin
      q0 = q0 + 17'd1;
    end
    return q0[15:0];
  endfunction

endpackage

### design/rsob_req_if.sv
// Request channel: valid/ready handshake with the blend or read payload.
// Depends on rsob_pkg.
interface rsob_req_if import rsob_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [POS_W-1:0]  x_pos;
  logic [POS_W-1:0]  y_pos;
  logic [CHAN_W-1:0] src_red;
  logic [CHAN_W-1:0] src_green;
  logic [CHAN_W-1:0] src_blue;
  logic [CHAN_W-1:0] src_opacity;
  logic [CHAN_W-1:0] coverage;

  modport source (
    output valid, req_type, x_pos, y_pos, src_red, src_green, src_blue,
           src_opacity, coverage,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_pos, y_pos, src_red, src_green, src_blue,
           src_opacity, coverage,
    output ready
  );
endinterface

### design/rsob_res_if.sv
// Result channel: valid/ready handshake with the pixel read-back payload.
// Depends on rsob_pkg.
interface rsob_res_if import rsob_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] pix_red;
  logic [CHAN_W-1:0] pix_green;
  logic [CHAN_W-1:0] pix_blue;
  logic [CHAN_W-1:0] pix_alpha;
  logic              inside_res;

  modport source (
    output valid, pix_red, pix_green, pix_blue, pix_alpha, inside_res,
    input  ready
  );
  modport sink (
    input  valid, pix_red, pix_green, pix_blue, pix_alpha, inside_res,
    output ready
  );
endinterface

### design/rsob_fifo.sv
// Small request queue between the front and back of the blend surface.
// Depends on rsob_pkg for the default depth.
module rsob_fifo import rsob_pkg::*; #(
  parameter int unsigned DW    = 1,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [DW-1:0] slot_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/rsob_front.sv
// Front end: surface size registers, request classification and queue push.
// Depends on rsob_pkg and rsob_req_if.
module rsob_front import rsob_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned AW = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                               $clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rsob_req_if.sink          req,
  input  rsob_apb_req_t     apb_i,
  output logic [APB_DW-1:0] prdata_o,
  input  logic              clear_busy_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output logic [AW-1:0]     q_addr_o,
  output rsob_item_t        q_item_o
);

  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [DIM_W-1:0] W_RST =
    DIM_W'((MAX_WIDTH < DIM_RESET) ? MAX_WIDTH : DIM_RESET);
  localparam logic [DIM_W-1:0] H_RST =
    DIM_W'((MAX_HEIGHT < DIM_RESET) ? MAX_HEIGHT : DIM_RESET);

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] wr_val, clamp_w, clamp_h;
  logic             wr_en;
  rsob_reg_e        reg_idx;
  logic             in_surf, is_read, keep;
  logic [XW-1:0]    x_idx;
  logic [YW-1:0]    y_idx;

  assign reg_idx = rsob_reg_e'(apb_i.addr[APB_AW-1]);
  assign wr_en   = apb_i.sel && apb_i.enable && apb_i.write;
  assign wr_val  = apb_i.wdata[DIM_W-1:0];
  // Clamp to the built surface size.
  assign clamp_w = (32'(wr_val) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : wr_val;
  assign clamp_h = (32'(wr_val) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : wr_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_RST;
      height_q <= H_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SURF_WIDTH:  width_q  <= clamp_w;
        REG_SURF_HEIGHT: height_q <= clamp_h;
        default:         width_q  <= width_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SURF_WIDTH:  prdata_o = APB_DW'(width_q);
      REG_SURF_HEIGHT: prdata_o = APB_DW'(height_q);
      default:         prdata_o = '0;
    endcase
  end

  assign in_surf = (req.x_pos < POS_W'(width_q)) && (req.y_pos < POS_W'(height_q));
  assign is_read = (req.req_type == REQ_READ);
  // Drop blends that land outside or carry no coverage.
  assign keep    = is_read || (in_surf && (req.coverage != '0));

  assign req.ready = !clear_busy_i && !q_full_i;
  assign q_push_o  = req.valid && req.ready && keep;

  assign x_idx    = req.x_pos[XW-1:0];
  assign y_idx    = req.y_pos[YW-1:0];
  assign q_addr_o = AW'(y_idx) * AW'(MAX_WIDTH) + AW'(x_idx);

  always_comb begin
    q_item_o.is_read   = is_read;
    q_item_o.in_surf   = in_surf;
    q_item_o.src_red   = req.src_red;
    q_item_o.src_green = req.src_green;
    q_item_o.src_blue  = req.src_blue;
    q_item_o.sa_prod   = 16'(req.src_opacity) * 16'(req.coverage);
  end

endmodule

### design/rsob_back.sv
// Back end: pixel memory, clearing pass, blend datapath with a shared
// 3-lane divider, and the result register. Depends on rsob_pkg, rsob_res_if.
module rsob_back import rsob_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned AW = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                               $clog2(MAX_WIDTH * MAX_HEIGHT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rsob_item_t    q_item_i,
  input  logic [AW-1:0] q_addr_i,
  output logic          q_pop_o,
  output logic          clear_busy_o,
  rsob_res_if.source    res
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam int unsigned NL = 3;

  rsob_state_e state_q, state_d;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_q;
  logic [AW-1:0]    clr_cnt_q, addr_q, waddr;
  logic [PIX_W-1:0] wdata;
  logic             mem_we, start;
  logic             is_read_q, inside_q;
  logic [CHAN_W-1:0] sc_q [NL];
  logic [CHAN_W-1:0] dc [NL];
  logic [CHAN_W-1:0] res_c [NL];
  logic [CHAN_W-1:0] sa_q, oa_q;
  logic [15:0]      sa_div, t_div, t_q;
  logic [23:0]      dct_q [NL];
  logic [15:0]      dct_div [NL];
  logic [15:0]      scsa_q [NL];
  logic [16:0]      num [NL];
  logic [16:0]      rem_q [NL];
  logic [CHAN_W-1:0] quo_q [NL];
  logic [NL-1:0]    sat_q;
  logic [14:0]      dv_q;
  logic [2:0]       cnt_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_inside_q;

  // Start only when a read item will find the result register free.
  assign start = !q_empty_i && (!q_item_i.is_read || !out_valid_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE:  if (start) state_d = ST_FETCH;
      ST_FETCH: state_d = is_read_q ? ST_IDLE : ST_MIX;
      ST_MIX:   state_d = ST_NUM;
      ST_NUM:   state_d = ST_DIV;
      ST_DIV:   if (cnt_q == '0) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o      = 1'b0;
    mem_we       = 1'b0;
    clear_busy_o = 1'b0;
    waddr        = addr_q;
    wdata        = {oa_q, res_c[2], res_c[1], res_c[0]};
    unique case (state_q)
      ST_CLEAR: begin
        clear_busy_o = 1'b1;
        mem_we       = 1'b1;
        waddr        = clr_cnt_q;
        wdata        = '0;
      end
      ST_IDLE:  q_pop_o = start;
      ST_WRITE: mem_we = 1'b1;
      default:  q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (state_q == ST_NUM) begin
        cnt_q <= 3'd7;
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (q_pop_o) begin
      rd_q <= mem[q_addr_i];
    end
  end

  assign dc[0] = rd_q[7:0];
  assign dc[1] = rd_q[15:8];
  assign dc[2] = rd_q[23:16];

  always_comb begin
    sa_div = div255(24'(q_item_i.sa_prod));
    t_div  = div255(24'(t_q));
    for (int i = 0; i < NL; i++) begin
      dct_div[i] = div255(dct_q[i]);
      num[i]     = 17'(scsa_q[i]) + 17'(dct_div[i]);
      if (oa_q == '0) begin
        res_c[i] = '0;
      end else if (sat_q[i]) begin
        res_c[i] = CHAN_MAX;
      end else begin
        res_c[i] = quo_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          addr_q    <= q_addr_i;
          is_read_q <= q_item_i.is_read;
          inside_q  <= q_item_i.in_surf;
          sc_q[0]   <= q_item_i.src_red;
          sc_q[1]   <= q_item_i.src_green;
          sc_q[2]   <= q_item_i.src_blue;
          sa_q      <= sa_div[7:0];
        end
      end
      ST_FETCH: begin
        t_q <= 16'(rd_q[31:24]) * 16'(CHAN_MAX - sa_q);
      end
      ST_MIX: begin
        oa_q <= sa_q + t_div[7:0];
        for (int i = 0; i < NL; i++) begin
          dct_q[i]  <= 24'(dc[i]) * 24'(t_q);
          scsa_q[i] <= 16'(sc_q[i]) * 16'(sa_q);
        end
      end
      ST_NUM: begin
        dv_q <= {oa_q, 7'h00};
        for (int i = 0; i < NL; i++) begin
          rem_q[i] <= num[i];
          sat_q[i] <= (num[i] >= {1'b0, oa_q, 8'h00});
        end
      end
      ST_DIV: begin
        // One restoring quotient bit per lane per cycle.
        dv_q <= dv_q >> 1;
        for (int i = 0; i < NL; i++) begin
          if (rem_q[i] >= 17'(dv_q)) begin
            rem_q[i] <= rem_q[i] - 17'(dv_q);
            quo_q[i] <= {quo_q[i][6:0], 1'b1};
          end else begin
            quo_q[i] <= {quo_q[i][6:0], 1'b0};
          end
        end
      end
      default: begin
        dv_q <= dv_q;
      end
    endcase
  end

  // Result register: load on a finished read, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FETCH && is_read_q) begin
      out_valid_q <= 1'b1;
    end else if (res.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH && is_read_q) begin
      out_pix_q    <= inside_q ? rd_q : '0;
      out_inside_q <= inside_q;
    end
  end

  assign res.valid      = out_valid_q;
  assign res.pix_red    = out_pix_q[7:0];
  assign res.pix_green  = out_pix_q[15:8];
  assign res.pix_blue   = out_pix_q[23:16];
  assign res.pix_alpha  = out_pix_q[31:24];
  assign res.inside_res = out_inside_q;

endmodule

### design/rgba8_source_over_blend_surface_top.sv
// Channel     Dir  Handshake        Payload
// req_i       in   valid/ready      req_type, x_pos, y_pos, src color, coverage
// res_o       out  valid/ready      pix bytes, inside_res (reads only)
// apb         in   psel/penable     surface_width @0x0, surface_height @0x4
//
// In the back end a read ends after the memory fetch; a blend runs through
// memory fetch, two multiply stages, the shared 3-lane restoring divider, write.
// Blends that are outside or carry zero coverage are dropped at the front
// in the cycle they are accepted and cost no back-end time.
// After reset the pixel memory is cleared one word per cycle, all
// MAX_WIDTH*MAX_HEIGHT words (65536 by default); no request is taken then.
// A 2-entry queue lets the front keep accepting while the back is busy.
// Depends on rsob_pkg, rsob_req_if, rsob_res_if, rsob_fifo, rsob_front,
// rsob_back and the assertion macro header.
`include "rgba8_source_over_blend_surface_top_macros.svh"
module rgba8_source_over_blend_surface_top import rsob_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rsob_req_if.sink          req_i,
  rsob_res_if.source        res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned AW = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                               $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
  localparam int unsigned QW = $bits(rsob_item_t) + AW;

  rsob_apb_req_t apb;
  logic          clear_busy, q_full, q_empty, q_push, q_pop;
  logic [AW-1:0] push_addr, pop_addr;
  rsob_item_t    push_item, pop_item;
  logic [QW-1:0] q_wdata, q_rdata;

  assign pready      = 1'b1;
  assign apb.sel     = psel;
  assign apb.enable  = penable;
  assign apb.write   = pwrite && pready;
  assign apb.addr    = paddr;
  assign apb.wdata   = pwdata;

  rsob_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .apb_i        (apb),
    .prdata_o     (prdata),
    .clear_busy_i (clear_busy),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_addr_o     (push_addr),
    .q_item_o     (push_item)
  );

  assign q_wdata = {push_addr, push_item};

  rsob_fifo #(
    .DW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign pop_addr = q_rdata[QW-1 -: AW];
  assign pop_item = rsob_item_t'(q_rdata[$bits(rsob_item_t)-1:0]);

  rsob_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_item_i     (pop_item),
    .q_addr_i     (pop_addr),
    .q_pop_o      (q_pop),
    .clear_busy_o (clear_busy),
    .res          (res_o)
  );

  `RSOB_ASSERT_IMPLY(a_no_accept_in_clear, clk_i, rst_ni, clear_busy, !req_i.ready, "request taken during clear")
  `RSOB_ASSERT_NEVER(a_queue_overflow, clk_i, rst_ni, q_push && q_full, "push into full queue")
  `RSOB_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && q_empty, "pop from empty queue")
  `RSOB_ASSERT_IMPLY(a_outside_zero, clk_i, rst_ni, res_o.valid && !res_o.inside_res, (res_o.pix_red == 8'd0) && (res_o.pix_green == 8'd0) && (res_o.pix_blue == 8'd0) && (res_o.pix_alpha == 8'd0), "outside read not zero")

endmodule

### tb/rgba8_source_over_blend_surface_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the RGBA8 source-over blend surface: drives blend and read requests, checks
// each pixel read-back against an in-bench copy of the surface, reprograms the size over APB.
// Depends on rsob_pkg, rsob_req_if, rsob_res_if and rgba8_source_over_blend_surface_top.
module rgba8_source_over_blend_surface_top_tb import rsob_pkg::*; ();

  localparam int unsigned CLK_HALF        = 4;
  localparam int unsigned BLEND_DRAIN     = 48;
  localparam int unsigned RES_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS    = 600;
  localparam int unsigned CHUNK_ITEMS     = 100;
  localparam int unsigned OPAQUE          = 255;
  localparam int unsigned PRINT_CAP       = 60;

  typedef struct {
    rsob_req_e         kind;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] opacity;
    logic [CHAN_W-1:0] cov;
  } pix_req_t;

  typedef struct {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              in_surf;
  } pix_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  rsob_req_if req_if ();
  rsob_res_if res_if ();

  // Surface image and size as the block should hold them.
  logic [PIX_W-1:0] surface_mem [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
  int unsigned      surf_w = DIM_RESET;
  int unsigned      surf_h = DIM_RESET;
  pix_res_t         readback_q [$];

  int unsigned mismatches     = 0;
  int unsigned reads_checked  = 0;
  int unsigned blends_applied = 0;
  int unsigned requests_sent  = 0;
  int unsigned effective_reqs = 0;
  int unsigned size_settings  = 0;
  bit          no_idle        = 1'b0;
  bit          hold_res_req   = 1'b0;

  rgba8_source_over_blend_surface_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_byte();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return CHAN_MAX;
    if (roll < 25) return 8'd1;
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  // Window origin: mostly well inside, sometimes straddling the far edge.
  function automatic logic [POS_W-1:0] pick_base(input int unsigned lim);
    if (lim == 0) return POS_W'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) return POS_W'((lim >= 4) ? lim - 4 : 0);
    return POS_W'($urandom_range(0, (lim > 8) ? lim - 8 : 0));
  endfunction

  function automatic pix_req_t mk_req(input rsob_req_e kind, input logic [POS_W-1:0] x,
                                      input logic [POS_W-1:0] y, input logic [CHAN_W-1:0] red,
                                      input logic [CHAN_W-1:0] green,
                                      input logic [CHAN_W-1:0] blue,
                                      input logic [CHAN_W-1:0] opacity,
                                      input logic [CHAN_W-1:0] cov);
    pix_req_t r;
    r.kind    = kind;
    r.x       = x;
    r.y       = y;
    r.red     = red;
    r.green   = green;
    r.blue    = blue;
    r.opacity = opacity;
    r.cov     = cov;
    return r;
  endfunction

  function automatic pix_req_t rand_req(input logic [POS_W-1:0] bx, input logic [POS_W-1:0] by);
    pix_req_t r;
    r = mk_req(($urandom_range(0, 99) < 55) ? REQ_BLEND : REQ_READ,
               bx + POS_W'($urandom_range(0, 7)), by + POS_W'($urandom_range(0, 7)),
               CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
               CHAN_W'($urandom_range(0, 255)), pick_byte(), pick_byte());
    // Some noise across the whole coordinate space.
    if ($urandom_range(0, 99) < 15) begin
      r.x = POS_W'($urandom);
      r.y = POS_W'($urandom);
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] mix_chan(input int unsigned sc, input int unsigned dc,
                                                 input int unsigned sa, input int unsigned da,
                                                 input int unsigned oa);
    int unsigned num;
    int unsigned q;
    if (oa == 0) return '0;
    num = sc * sa + (dc * da * (OPAQUE - sa)) / OPAQUE;
    q   = num / oa;
    return (q > OPAQUE) ? CHAN_MAX : CHAN_W'(q);
  endfunction

  // Apply one accepted request to the surface image; queue the read-back it causes.
  // Return whether the request does anything at all.
  function automatic bit surface_apply(input pix_req_t r);
    bit               in_surf;
    int unsigned      addr;
    int unsigned      sa;
    int unsigned      da;
    int unsigned      oa;
    logic [PIX_W-1:0] word;
    pix_res_t         res;
    in_surf = (r.x < surf_w) && (r.y < surf_h);
    addr    = in_surf ? int'(r.y) * MAX_WIDTH_DEF + int'(r.x) : 0;
    if (r.kind == REQ_READ) begin
      word        = in_surf ? surface_mem[addr] : '0;
      res.red     = word[7:0];
      res.green   = word[15:8];
      res.blue    = word[23:16];
      res.alpha   = word[31:24];
      res.in_surf = in_surf;
      readback_q.push_back(res);
      return 1'b1;
    end
    if (!in_surf || r.cov == 0) return 1'b0;
    word = surface_mem[addr];
    sa   = (int'(r.opacity) * int'(r.cov)) / OPAQUE;
    da   = word[31:24];
    oa   = sa + (da * (OPAQUE - sa)) / OPAQUE;
    surface_mem[addr] = {CHAN_W'(oa),
                         mix_chan(r.blue, word[23:16], sa, da, oa),
                         mix_chan(r.green, word[15:8], sa, da, oa),
                         mix_chan(r.red, word[7:0], sa, da, oa)};
    blends_applied++;
    return 1'b1;
  endfunction

  task automatic send_req(input pix_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.kind;
    req_if.x_pos       <= r.x;
    req_if.y_pos       <= r.y;
    req_if.src_red     <= r.red;
    req_if.src_green   <= r.green;
    req_if.src_blue    <= r.blue;
    req_if.src_opacity <= r.opacity;
    req_if.coverage    <= r.cov;
    do @(posedge clk_i); while (!req_if.ready);
    requests_sent++;
    if (surface_apply(r)) effective_reqs++;
  endtask

  // Drop valid, wait out pending reads, then let any trailing blend retire.
  task automatic finish_burst();
    req_if.valid <= 1'b0;
    while (readback_q.size() != 0) @(posedge clk_i);
    repeat (BLEND_DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input rsob_reg_e idx, input logic [APB_DW-1:0] val);
    int unsigned dim;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    dim = val[DIM_W-1:0];
    if (idx == REG_SURF_WIDTH) surf_w = (dim > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : dim;
    else surf_h = (dim > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : dim;
  endtask

  task automatic set_surface(input logic [APB_DW-1:0] width_val,
                             input logic [APB_DW-1:0] height_val);
    write_reg(REG_SURF_WIDTH, width_val);
    write_reg(REG_SURF_HEIGHT, height_val);
    size_settings++;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_readback
    pix_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (readback_q.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: result with none pending, expected nothing, actual %0d/%0d/%0d/%0d/%0d",
                   $time, res_if.pix_red, res_if.pix_green, res_if.pix_blue, res_if.pix_alpha,
                   res_if.inside_res);
      end else begin
        want = readback_q.pop_front();
        check_field("pix_red", want.red, res_if.pix_red);
        check_field("pix_green", want.green, res_if.pix_green);
        check_field("pix_blue", want.blue, res_if.pix_blue);
        check_field("pix_alpha", want.alpha, res_if.pix_alpha);
        check_field("inside_res", want.in_surf, res_if.inside_res);
        reads_checked++;
      end
    end
  end

  // Result side: random stalls, or one long hold when a test requests it.
  initial begin : drive_res_ready
    int stall;
    res_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_res_req) begin
        res_if.ready <= 1'b0;
        repeat (RES_HOLD_CYCLES) @(posedge clk_i);
        hold_res_req = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic test_corner_requests();
    send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk_req(REQ_BLEND, 0, 0, 255, 0, 128, 255, 255));
    send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    // zero coverage leaves the pixel alone
    send_req(mk_req(REQ_BLEND, 0, 0, 0, 255, 0, 255, 0));
    send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk_req(REQ_BLEND, 256, 0, 255, 255, 255, 255, 255));
    send_req(mk_req(REQ_READ, 256, 0, 0, 0, 0, 0, 0));
    send_req(mk_req(REQ_READ, 16'hFFFF, 16'hFFFF, 255, 255, 255, 255, 255));
    send_req(mk_req(REQ_BLEND, 255, 255, 10, 20, 30, 128, 200));
    send_req(mk_req(REQ_READ, 255, 255, 0, 0, 0, 0, 0));
    // alpha-1 pixel under a faint white source: the color quotient overflows
    send_req(mk_req(REQ_BLEND, 1, 0, 255, 255, 255, 255, 1));
    send_req(mk_req(REQ_BLEND, 1, 0, 255, 255, 255, 255, 1));
    send_req(mk_req(REQ_READ, 1, 0, 0, 0, 0, 0, 0));
    // effective alpha rounds to zero on an empty pixel: colors stay zero
    send_req(mk_req(REQ_BLEND, 2, 0, 200, 100, 50, 1, 1));
    send_req(mk_req(REQ_BLEND, 2, 0, 200, 100, 50, 0, 255));
    send_req(mk_req(REQ_READ, 2, 0, 0, 0, 0, 0, 0));
    send_req(mk_req(REQ_BLEND, 0, 0, 0, 255, 0, 128, 255));
    send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0));
    send_req(mk_req(REQ_BLEND, 3, 16'h8000, 1, 2, 3, 255, 255));
    send_req(mk_req(REQ_READ, 3, 16'h8000, 0, 0, 0, 0, 0));
    send_req(mk_req(REQ_READ, 0, 255, 0, 0, 0, 0, 0));
    finish_burst();
  endtask

  task automatic test_surface_config();
    int unsigned      cfg_w [7] = '{0, 256, 1, 511, 300, 17, 256};
    int unsigned      cfg_h [7] = '{256, 0, 1, 511, 200, 300, 256};
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] by;
    logic [APB_DW-1:0] junk;
    for (int i = 0; i < 7; i++) begin
      // upper data bits are not part of the register
      junk = ($urandom_range(0, 1) == 1) ? ($urandom & 32'hFFFF_FE00) : '0;
      set_surface(junk | cfg_w[i], junk | cfg_h[i]);
      bx = pick_base(surf_w);
      by = pick_base(surf_h);
      for (int k = 0; k < 20; k++) send_req(rand_req(bx, by));
      finish_burst();
    end
  endtask

  task automatic test_result_stall();
    no_idle      = 1'b1;
    hold_res_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send_req(mk_req(i[0] ? REQ_READ : REQ_BLEND, POS_W'(i / 2), 5,
                      CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), 200, 255));
    end
    no_idle = 1'b0;
    finish_burst();
  endtask

  task automatic test_random_traffic();
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] by;
    int unsigned      start;
    int               roll;
    start = requests_sent;
    while (requests_sent - start < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 3);
      if (roll < 2) set_surface(256, 256);
      else if (roll == 2) set_surface($urandom_range(1, 511), $urandom_range(1, 511));
      else set_surface($urandom_range(1, 16), $urandom_range(1, 16));
      no_idle = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < CHUNK_ITEMS; k++) begin
        // move the hot window now and then so pixels get blended repeatedly
        if (k % 25 == 0) begin
          bx = pick_base(surf_w);
          by = pick_base(surf_h);
        end
        send_req(rand_req(bx, by));
      end
      no_idle = 1'b0;
      finish_burst();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_BLEND;
    req_if.x_pos       = '0;
    req_if.y_pos       = '0;
    req_if.src_red     = '0;
    req_if.src_green   = '0;
    req_if.src_blue    = '0;
    req_if.src_opacity = '0;
    req_if.coverage    = '0;
    foreach (surface_mem[i]) surface_mem[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_requests();
    test_surface_config();
    test_result_stall();
    test_random_traffic();

    $display("Sent %0d requests (%0d took effect): %0d blends changed a pixel, %0d read-backs checked.",
             requests_sent, effective_reqs, blends_applied, reads_checked);
    $display("Went through %0d surface sizes and one long result-side stall.", size_settings);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
